### hw/rtl/swd_seq_pkg.sv
`timescale 1ns / 1ps

package swd_seq_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      CMD_HOST = 2'd0,
      CMD_LINK = 2'd1,
      CMD_EOP  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // result word kinds
   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_READ   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_FLUSH    = 4'd1,
      PH_PIPE     = 4'd2,
      PH_MPOST    = 4'd3,
      PH_MREAD    = 4'd4,
      PH_POST     = 4'd5,
      PH_DPREAD   = 4'd6,
      PH_WRITE    = 4'd7,
      PH_ENDFLUSH = 4'd8
   } phase_type;

   localparam logic [2:0] ACK_OK   = 3'd1;
   localparam logic [2:0] ACK_WAIT = 3'd2;

   localparam logic [4:0] STATUS_MISMATCH = 5'h11;

   // request flag bit positions
   localparam int REQ_AP       = 0;
   localparam int REQ_RNW      = 1;
   localparam int REQ_MATCHVAL = 4;
   localparam int REQ_MASKSET  = 5;

   localparam logic [3:0] RDBUFF_REQ = 4'hE;

   localparam logic [15:0] WAIT_RETRY_RESET = 16'd100;

   // configuration register indexes
   localparam logic CSR_WAIT_RETRY  = 1'b0;
   localparam logic CSR_MATCH_RETRY = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  link_request;
      logic [31:0] link_wdata;
      logic [31:0] read_data;
      logic [7:0]  done_count;
      logic [4:0]  status_ack;
      logic        last;
   } result_type;

   function automatic result_type mk_command(phase_type ph, logic [5:0] req,
                                              logic [31:0] value);
      result_type r;
      r = '0;
      r.kind = KIND_CMD;
      r.link_request = req[3:0];
      if (ph == PH_FLUSH || ph == PH_ENDFLUSH) begin
         r.link_request = RDBUFF_REQ;
      end else if (ph == PH_MREAD && req[REQ_AP]) begin
         r.link_request = RDBUFF_REQ;
      end else if (ph == PH_WRITE) begin
         r.link_wdata = value;
      end
      return r;
   endfunction

   function automatic result_type mk_read(logic [31:0] data);
      result_type r;
      r = '0;
      r.kind = KIND_READ;
      r.read_data = data;
      return r;
   endfunction

   function automatic result_type mk_status(logic [7:0] cnt, logic [4:0] st);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.done_count = cnt;
      r.status_ack = st;
      return r;
   endfunction

endpackage

### hw/rtl/swd_transfer_sequencer.sv
`timescale 1ns / 1ps

// SWD transfer sequencer
// req channel carries one word per item: a host transfer request, a link
// response (ack and read data) or an end-of-packet marker, selected by req_cmd.
// rsp channel returns link commands, read words for the host and the packet
// status; rsp_last marks the final word caused by one req word.
// an accepted req word is held in an input register and evaluated once the
// output queue has room for two words; its results are registered into a
// four-word output queue, whose head word drives rsp.
// one req word is taken per cycle while the output queue has room for two
// words; an item yields at most two results, so the queue drain rate on rsp
// sets the sustained rate when most items produce output.
// csr port: index 0 wait_retry, index 1 match_retry; write only while idle.
// reset empties the queue, drops the held word, sets wait_retry to 100 and
// all packet state to zero.
// when rsp_stall is high the head word holds and the queue fills; once it
// cannot take two more words the input register stalls and req_stall rises.
module swd_transfer_sequencer
   import swd_seq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_request,
   input  logic [31:0] req_host_data,
   input  logic [2:0]  req_link_ack,
   input  logic [31:0] req_link_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_link_request,
   output logic [31:0] rsp_link_wdata,
   output logic [31:0] rsp_read_data,
   output logic [7:0]  rsp_done_count,
   output logic [4:0]  rsp_status_ack,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_cmd_ff;
   logic [5:0]  in_request_ff;
   logic [31:0] in_host_data_ff;
   logic [2:0]  in_link_ack_ff;
   logic [31:0] in_link_data_ff;

   // configuration
   logic [15:0] wait_retry_ff;
   logic [15:0] match_retry_ff;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic        posted_read_ff, posted_read_in;
   logic [7:0]  transfer_count_ff, transfer_count_in;
   logic [4:0]  last_status_ff, last_status_in;
   logic        aborted_ff, aborted_in;
   logic [31:0] match_mask_ff, match_mask_in;
   logic [5:0]  held_request_ff, held_request_in;
   logic [31:0] held_value_ff, held_value_in;
   logic [15:0] wait_left_ff, wait_left_in;
   logic [15:0] match_left_ff, match_left_in;

   // output queue
   result_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]       count_ff, count_in;

   result_type res_arr [2];
   logic [1:0] res_cnt;
   logic       do_body;
   logic       proc_fire;
   logic       rsp_pop;
   result_type head;

   assign proc_fire = in_valid_ff && (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
   assign req_stall = in_valid_ff && !proc_fire;
   assign rsp_pop   = rsp_valid && !rsp_stall;

   // next state and result words for the held item
   always_comb begin
      phase_in          = phase_ff;
      posted_read_in    = posted_read_ff;
      transfer_count_in = transfer_count_ff;
      last_status_in    = last_status_ff;
      aborted_in        = aborted_ff;
      match_mask_in     = match_mask_ff;
      held_request_in   = held_request_ff;
      held_value_in     = held_value_ff;
      wait_left_in      = wait_left_ff;
      match_left_in     = match_left_ff;
      res_arr[0]        = '0;
      res_arr[1]        = '0;
      res_cnt           = 2'd0;
      do_body           = 1'b0;

      if (proc_fire) begin
         case (cmd_type'(in_cmd_ff))
            CMD_HOST: begin
               if (phase_ff == PH_IDLE && !aborted_ff) begin
                  held_request_in = in_request_ff;
                  held_value_in   = in_host_data_ff;
                  if (posted_read_ff) begin
                     // a plain AP read collects the previous posted word
                     if (in_request_ff[REQ_RNW] && in_request_ff[REQ_AP]
                         && !in_request_ff[REQ_MATCHVAL]) begin
                        phase_in = PH_PIPE;
                     end else begin
                        phase_in = PH_FLUSH;
                     end
                     wait_left_in = wait_retry_ff;
                     res_arr[res_cnt[0]] = mk_command(phase_in, held_request_in,
                                                      held_value_in);
                     res_cnt = res_cnt + 2'd1;
                  end else begin
                     do_body = 1'b1;
                  end
               end
            end
            CMD_LINK: begin
               if (phase_ff != PH_IDLE) begin
                  if (in_link_ack_ff == ACK_WAIT && wait_left_ff != 16'd0) begin
                     wait_left_in = wait_left_ff - 16'd1;
                     res_arr[res_cnt[0]] = mk_command(phase_ff, held_request_ff,
                                                      held_value_ff);
                     res_cnt = res_cnt + 2'd1;
                  end else begin
                     last_status_in = {2'b00, in_link_ack_ff};
                     if (in_link_ack_ff != ACK_OK) begin
                        if (phase_ff == PH_ENDFLUSH) begin
                           res_arr[res_cnt[0]] = mk_status(transfer_count_ff,
                                                           last_status_in);
                           res_cnt = res_cnt + 2'd1;
                           transfer_count_in = 8'd0;
                           last_status_in    = 5'd0;
                           aborted_in        = 1'b0;
                           posted_read_in    = 1'b0;
                        end else begin
                           aborted_in = 1'b1;
                        end
                        phase_in = PH_IDLE;
                     end else begin
                        case (phase_ff)
                           PH_FLUSH: begin
                              res_arr[res_cnt[0]] = mk_read(in_link_data_ff);
                              res_cnt = res_cnt + 2'd1;
                              posted_read_in = 1'b0;
                              do_body = 1'b1;
                           end
                           PH_PIPE, PH_DPREAD: begin
                              res_arr[res_cnt[0]] = mk_read(in_link_data_ff);
                              res_cnt = res_cnt + 2'd1;
                              if (transfer_count_ff != 8'hFF) begin
                                 transfer_count_in = transfer_count_ff + 8'd1;
                              end
                              phase_in = PH_IDLE;
                           end
                           PH_MPOST: begin
                              match_left_in = match_retry_ff;
                              phase_in      = PH_MREAD;
                              wait_left_in  = wait_retry_ff;
                              res_arr[res_cnt[0]] = mk_command(PH_MREAD,
                                 held_request_ff, held_value_ff);
                              res_cnt = res_cnt + 2'd1;
                           end
                           PH_MREAD: begin
                              if ((in_link_data_ff & match_mask_ff) == held_value_ff) begin
                                 if (transfer_count_ff != 8'hFF) begin
                                    transfer_count_in = transfer_count_ff + 8'd1;
                                 end
                                 phase_in = PH_IDLE;
                              end else if (match_left_ff != 16'd0) begin
                                 match_left_in = match_left_ff - 16'd1;
                                 wait_left_in  = wait_retry_ff;
                                 res_arr[res_cnt[0]] = mk_command(PH_MREAD,
                                    held_request_ff, held_value_ff);
                                 res_cnt = res_cnt + 2'd1;
                              end else begin
                                 last_status_in = STATUS_MISMATCH;
                                 aborted_in     = 1'b1;
                                 phase_in       = PH_IDLE;
                              end
                           end
                           PH_POST: begin
                              posted_read_in = 1'b1;
                              if (transfer_count_ff != 8'hFF) begin
                                 transfer_count_in = transfer_count_ff + 8'd1;
                              end
                              phase_in = PH_IDLE;
                           end
                           PH_WRITE: begin
                              if (transfer_count_ff != 8'hFF) begin
                                 transfer_count_in = transfer_count_ff + 8'd1;
                              end
                              phase_in = PH_IDLE;
                           end
                           PH_ENDFLUSH: begin
                              res_arr[res_cnt[0]] = mk_read(in_link_data_ff);
                              res_cnt = res_cnt + 2'd1;
                              res_arr[res_cnt[0]] = mk_status(transfer_count_ff,
                                                              last_status_in);
                              res_cnt = res_cnt + 2'd1;
                              transfer_count_in = 8'd0;
                              last_status_in    = 5'd0;
                              aborted_in        = 1'b0;
                              posted_read_in    = 1'b0;
                              phase_in          = PH_IDLE;
                           end
                           default: begin
                              phase_in = PH_IDLE;
                           end
                        endcase
                     end
                  end
               end
            end
            CMD_EOP: begin
               if (phase_ff == PH_IDLE) begin
                  if (posted_read_ff && !aborted_ff) begin
                     phase_in     = PH_ENDFLUSH;
                     wait_left_in = wait_retry_ff;
                     res_arr[res_cnt[0]] = mk_command(PH_ENDFLUSH, held_request_ff,
                                                      held_value_ff);
                     res_cnt = res_cnt + 2'd1;
                  end else begin
                     res_arr[res_cnt[0]] = mk_status(transfer_count_ff,
                                                     last_status_ff);
                     res_cnt = res_cnt + 2'd1;
                     transfer_count_in = 8'd0;
                     last_status_in    = 5'd0;
                     aborted_in        = 1'b0;
                     posted_read_in    = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase

         // start of a fresh transfer body
         if (do_body) begin
            if (held_request_in[REQ_RNW]) begin
               if (held_request_in[REQ_MATCHVAL]) begin
                  if (held_request_in[REQ_AP]) begin
                     phase_in = PH_MPOST;
                  end else begin
                     match_left_in = match_retry_ff;
                     phase_in      = PH_MREAD;
                  end
               end else if (held_request_in[REQ_AP]) begin
                  phase_in = PH_POST;
               end else begin
                  phase_in = PH_DPREAD;
               end
            end else if (held_request_in[REQ_MASKSET]) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_WRITE;
            end

            if (!held_request_in[REQ_RNW] && held_request_in[REQ_MASKSET]) begin
               match_mask_in = held_value_in;
               if (transfer_count_in != 8'hFF) begin
                  transfer_count_in = transfer_count_in + 8'd1;
               end
            end else begin
               wait_left_in = wait_retry_ff;
               res_arr[res_cnt[0]] = mk_command(phase_in, held_request_in,
                                                held_value_in);
               res_cnt = res_cnt + 2'd1;
            end
         end

         if (res_cnt == 2'd1) begin
            res_arr[0].last = 1'b1;
         end else if (res_cnt == 2'd2) begin
            res_arr[1].last = 1'b1;
         end
      end
   end

   assign count_in = count_ff + {1'b0, res_cnt} - {{QUEUE_AW{1'b0}}, rsp_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         wait_retry_ff     <= WAIT_RETRY_RESET;
         match_retry_ff    <= 16'd0;
         phase_ff          <= PH_IDLE;
         posted_read_ff    <= 1'b0;
         transfer_count_ff <= 8'd0;
         last_status_ff    <= 5'd0;
         aborted_ff        <= 1'b0;
         match_mask_ff     <= 32'd0;
         held_request_ff   <= 6'd0;
         held_value_ff     <= 32'd0;
         wait_left_ff      <= 16'd0;
         match_left_ff     <= 16'd0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (proc_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_WAIT_RETRY:  wait_retry_ff  <= csr_wdata;
               CSR_MATCH_RETRY: match_retry_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         phase_ff          <= phase_in;
         posted_read_ff    <= posted_read_in;
         transfer_count_ff <= transfer_count_in;
         last_status_ff    <= last_status_in;
         aborted_ff        <= aborted_in;
         match_mask_ff     <= match_mask_in;
         held_request_ff   <= held_request_in;
         held_value_ff     <= held_value_in;
         wait_left_ff      <= wait_left_in;
         match_left_ff     <= match_left_in;
         wr_ptr_ff         <= wr_ptr_ff + QUEUE_AW'(res_cnt);
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // input payload and queue storage
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff       <= req_cmd;
         in_request_ff   <= req_request;
         in_host_data_ff <= req_host_data;
         in_link_ack_ff  <= req_link_ack;
         in_link_data_ff <= req_link_data;
      end
      if (res_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res_arr[0];
      end
      if (res_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= res_arr[1];
      end
   end

   assign head = queue_ff[rd_ptr_ff];

   always_comb begin
      rsp_valid        = (count_ff != '0);
      rsp_kind         = head.kind;
      rsp_link_request = head.link_request;
      rsp_link_wdata   = head.link_wdata;
      rsp_read_data    = head.read_data;
      rsp_done_count   = head.done_count;
      rsp_status_ack   = head.status_ack;
      rsp_last         = head.last;
   end

endmodule

### hw/rtl/swd_seq_checker.sv
`timescale 1ns / 1ps

module swd_seq_checker
   import swd_seq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_link_request,
   input logic [31:0] rsp_read_data,
   input logic        rsp_last
);

   // queue comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_read_data) && $stable(rsp_last))
      else $error("rsp word changed under stall");

   // the packet status always closes the results of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last)
      else $error("status word without last");

   // only link commands carry a request, only read words carry data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CMD |-> rsp_link_request == 4'd0)
      else $error("request bits on a non-command word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_READ |-> rsp_read_data == 32'd0)
      else $error("read data on a non-read word");

endmodule

bind swd_transfer_sequencer swd_seq_checker u_swd_seq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_link_request (rsp_link_request),
   .rsp_read_data    (rsp_read_data),
   .rsp_last         (rsp_last)
);
